>>> hdl/ats_pkg.sv
// Shared types, constants and helper functions for the tilt angle smoother.
package ats_pkg;

    localparam int TABLE_LEN   = 24;
    localparam int ANG_W       = 26;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int INV_GAIN_W  = 20;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q20 = 20'd636751;
    localparam logic signed [16:0] ROLL_LIMIT  = 17'sd46080;
    localparam logic signed [16:0] PITCH_LIMIT = 17'sd23040;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCALE  = 3'd0,
        REG_OFFS_X = 3'd1,
        REG_OFFS_Y = 3'd2,
        REG_OFFS_Z = 3'd3,
        REG_WEIGHT = 3'd4
    } cfg_reg_t;

    typedef logic signed [ANG_W-1:0] angle_t;

    // atan(2^-i) in 2^-16 degree
    function automatic angle_t atan_entry(input logic [4:0] i);
        angle_t r;
        case (i)
            5'd0:  r = 26'sd2949120;
            5'd1:  r = 26'sd1740967;
            5'd2:  r = 26'sd919879;
            5'd3:  r = 26'sd466945;
            5'd4:  r = 26'sd234379;
            5'd5:  r = 26'sd117304;
            5'd6:  r = 26'sd58666;
            5'd7:  r = 26'sd29335;
            5'd8:  r = 26'sd14668;
            5'd9:  r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;
            5'd19: r = 26'sd7;
            5'd20: r = 26'sd4;
            5'd21: r = 26'sd2;
            5'd22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    // Round 2^-16 degree to 1/256 degree (half up), then clamp to +-lim.
    function automatic logic signed [16:0] round_clamp(input logic signed [33:0] a,
                                                       input logic signed [16:0] lim);
        logic signed [34:0] s;
        logic signed [26:0] q;
        logic signed [26:0] l;
        s = 35'(a) + 35'sd128;
        q = 27'(s >>> 8);
        l = 27'(lim);
        if (q > l)
            return lim;
        else if (q < -l)
            return -lim;
        return 17'(q);
    endfunction

endpackage

>>> hdl/ats_if.sv
// Channel interfaces: sample input, result output and register write port.
interface tilt_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] z_raw;
    modport source (output valid, x_raw, y_raw, z_raw, input ready);
    modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface tilt_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_instant;
    logic signed [15:0] pitch_instant;
    logic signed [16:0] roll_smoothed;
    logic signed [15:0] pitch_smoothed;
    modport source (output valid, roll_instant, pitch_instant, roll_smoothed,
                    pitch_smoothed, input ready);
    modport sink   (input valid, roll_instant, pitch_instant, roll_smoothed,
                    pitch_smoothed, output ready);
endinterface

interface tilt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [20:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

>>> hdl/ats_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
module ats_cordic
    import ats_pkg::*;
#(
    parameter int DW    = 42,
    parameter int STEPS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] re_in,
    input  logic signed [DW-1:0] im_in,
    output logic                 done,
    output angle_t               ang,
    output logic signed [DW-1:0] mag
);

    logic signed [DW-1:0] re_reg, re_next, im_reg, im_next;
    angle_t               z_reg, z_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 run_reg, run_next, done_reg, done_next;
    logic signed [DW-1:0] dr, di;

    assign dr = im_reg >>> cnt_reg;
    assign di = re_reg >>> cnt_reg;

    always_comb
    begin
        re_next   = re_reg;
        im_next   = im_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = '0;
            if (re_in == '0 && im_in == '0)
            begin
                re_next   = '0;
                im_next   = '0;
                z_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                run_next = 1'b1;
                re_next  = re_in;
                im_next  = im_in;
                z_next   = '0;
                // pre-rotate into the right half plane
                if (re_in < 0)
                begin
                    if (im_in >= 0)
                    begin
                        re_next = im_in;
                        im_next = -re_in;
                        z_next  = 26'sd5898240;
                    end
                    else
                    begin
                        re_next = -im_in;
                        im_next = re_in;
                        z_next  = -26'sd5898240;
                    end
                end
            end
        end
        else if (run_reg)
        begin
            if (im_reg >= 0)
            begin
                re_next = re_reg + dr;
                im_next = im_reg - di;
                z_next  = z_reg + atan_entry(cnt_reg);
            end
            else
            begin
                re_next = re_reg - dr;
                im_next = im_reg + di;
                z_next  = z_reg - atan_entry(cnt_reg);
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg <= re_next;
        im_reg <= im_next;
        z_reg  <= z_next;
    end

    assign done = done_reg;
    assign ang  = z_reg;
    assign mag  = (re_reg < 0) ? '0 : re_reg;

endmodule

>>> hdl/accel_tilt_angle_smoother.sv
// Tilt roll/pitch from one accelerometer sample, with exponential moving-average smoothing.
// Steps: scale the three axes, roll CORDIC, gain correction, pitch CORDIC, roll and pitch
//   blends, output register; the first sample after reset skips the blends, a zero vector skips its CORDIC steps.
// Samples: a new sample is taken only once the last one is loaded into the output register, set by
//   the shared adder and the CORDIC unit; sample.ready is high only when idle, and a stalled result holds it low.
// Reset: registers take their defaults, averages clear and reload from the first sample.
module accel_tilt_angle_smoother
    import ats_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ACCEL_FRAC_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    tilt_cfg_if.sink    cfg,
    tilt_in_if.sink     sample,
    tilt_out_if.source  result
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SHL   = (ACCEL_FRAC_BITS >= 16) ? ACCEL_FRAC_BITS - 16 : 0;
    localparam int SHR   = (ACCEL_FRAC_BITS < 16) ? 16 - ACCEL_FRAC_BITS : 0;
    localparam int DW    = 38 + SHL;
    localparam int AW    = DW + INV_GAIN_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCALE, ST_ROLL, ST_GAIN, ST_PITCH, ST_BLEND_R, ST_BLEND_P, ST_FINISH
    } state_t;

    state_t state_reg;

    logic [15:0]        scale_reg;
    logic signed [20:0] offs_x_reg, offs_y_reg, offs_z_reg;
    logic [16:0]        weight_reg;

    logic signed [15:0] x_reg, y_reg, z_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, az_reg;
    logic [1:0]         axis_reg;
    logic               start_reg;
    logic signed [DW-1:0] c_re, c_im, c_mag;
    logic               c_done;
    angle_t             c_ang, roll_ang_reg;

    logic signed [AW-1:0] acc_reg, acc_next, addend;
    logic signed [DW-1:0] mag_reg;
    logic signed [33:0]   diff_reg;
    logic [4:0]           k_reg;
    logic                 bit_on;

    logic signed [31:0] roll_avg_reg, pitch_avg_reg;
    logic               loaded_reg;
    logic signed [16:0] roll_i_reg, pitch_i_reg;
    logic signed [16:0] roll_i, pitch_i;
    logic [16:0]        w_eff;

    logic               out_valid_reg;
    logic               load_out;
    logic signed [16:0] out_roll_i_reg, out_roll_s_reg;
    logic signed [15:0] out_pitch_i_reg, out_pitch_s_reg;

    // scaling: one axis per cycle through the single multiplier
    logic signed [15:0] raw_sel;
    logic signed [20:0] off_sel;
    logic signed [32:0] prod;
    logic signed [33:0] gdiff;
    logic signed [DW-1:0] gval;
    logic signed [34:0] blend_sum;
    logic signed [AW-1:0] r_round;

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin raw_sel = x_reg; off_sel = offs_x_reg; end
            2'd1:    begin raw_sel = y_reg; off_sel = offs_y_reg; end
            default: begin raw_sel = z_reg; off_sel = offs_z_reg; end
        endcase
    end

    assign prod  = 33'(raw_sel) * $signed({17'd0, scale_reg});
    assign gdiff = 34'(prod) - 34'(off_sel);
    assign gval  = (DW'(gdiff) <<< SHL) >>> SHR;

    assign w_eff  = weight_reg[16] ? 17'h10000 : weight_reg;
    assign bit_on = (state_reg == ST_GAIN) ? INV_GAIN_Q20[k_reg] : w_eff[k_reg];
    assign addend = (state_reg == ST_GAIN) ? (AW'(mag_reg) <<< k_reg)
                                           : (AW'(diff_reg) <<< k_reg);
    assign acc_next  = bit_on ? acc_reg + addend : acc_reg;
    assign r_round   = (acc_next + (AW'(1) <<< (INV_GAIN_W - 1))) >>> INV_GAIN_W;
    assign blend_sum = 35'(roll_avg_reg) + 35'(acc_next >>> 16);

    assign c_re = (state_reg == ST_PITCH) ? mag_reg : az_reg;
    assign c_im = (state_reg == ST_PITCH) ? -ax_reg : ay_reg;

    assign roll_i  = round_clamp(34'(roll_ang_reg), ROLL_LIMIT);
    assign pitch_i = round_clamp(34'(c_ang), PITCH_LIMIT);

    // load the output register once it is free or drains this cycle
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    ats_cordic #(.DW(DW), .STEPS(STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .re_in (c_re),
        .im_in (c_im),
        .done  (c_done),
        .ang   (c_ang),
        .mag   (c_mag)
    );

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 16'd256;
            offs_x_reg <= 21'sd0;
            offs_y_reg <= 21'sd6554;
            offs_z_reg <= -21'sd6554;
            weight_reg <= 17'd6554;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_SCALE:  scale_reg  <= cfg.data[15:0];
                REG_OFFS_X: offs_x_reg <= cfg.data;
                REG_OFFS_Y: offs_y_reg <= cfg.data;
                REG_OFFS_Z: offs_z_reg <= cfg.data;
                REG_WEIGHT: weight_reg <= cfg.data[16:0];
                default:    ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            start_reg     <= 1'b0;
            k_reg         <= '0;
            loaded_reg    <= 1'b0;
            roll_avg_reg  <= '0;
            pitch_avg_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        x_reg     <= sample.x_raw;
                        y_reg     <= sample.y_raw;
                        z_reg     <= sample.z_raw;
                        axis_reg  <= 2'd0;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    case (axis_reg)
                        2'd0:    ax_reg <= gval;
                        2'd1:    ay_reg <= gval;
                        default: az_reg <= gval;
                    endcase
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_ROLL;
                    end
                end
                ST_ROLL:
                begin
                    if (c_done)
                    begin
                        roll_ang_reg <= c_ang;
                        mag_reg      <= c_mag;
                        acc_reg      <= '0;
                        k_reg        <= '0;
                        state_reg    <= ST_GAIN;
                    end
                end
                ST_GAIN:
                begin
                    acc_reg <= acc_next;
                    k_reg   <= k_reg + 5'd1;
                    if (k_reg == 5'(INV_GAIN_W - 1))
                    begin
                        mag_reg   <= DW'(r_round);
                        start_reg <= 1'b1;
                        state_reg <= ST_PITCH;
                    end
                end
                ST_PITCH:
                begin
                    if (c_done)
                    begin
                        roll_i_reg  <= roll_i;
                        pitch_i_reg <= pitch_i;
                        if (!loaded_reg)
                        begin
                            roll_avg_reg  <= 32'(roll_i) <<< 8;
                            pitch_avg_reg <= 32'(pitch_i) <<< 8;
                            loaded_reg    <= 1'b1;
                            state_reg     <= ST_FINISH;
                        end
                        else
                        begin
                            diff_reg  <= (34'(roll_i) <<< 8) - 34'(roll_avg_reg);
                            acc_reg   <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_BLEND_R;
                        end
                    end
                end
                ST_BLEND_R:
                begin
                    acc_reg <= acc_next;
                    k_reg   <= k_reg + 5'd1;
                    if (k_reg == 5'd16)
                    begin
                        roll_avg_reg <= blend_sum[31:0];
                        diff_reg     <= (34'(pitch_i_reg) <<< 8) - 34'(pitch_avg_reg);
                        acc_reg      <= '0;
                        k_reg        <= '0;
                        state_reg    <= ST_BLEND_P;
                    end
                end
                ST_BLEND_P:
                begin
                    acc_reg <= acc_next;
                    k_reg   <= k_reg + 5'd1;
                    if (k_reg == 5'd16)
                    begin
                        pitch_avg_reg <= 32'(35'(pitch_avg_reg) + 35'(acc_next >>> 16));
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (load_out)
                    begin
                        out_roll_i_reg  <= roll_i_reg;
                        out_pitch_i_reg <= pitch_i_reg[15:0];
                        out_roll_s_reg  <= round_clamp(34'(roll_avg_reg), ROLL_LIMIT);
                        out_pitch_s_reg <= 16'(round_clamp(34'(pitch_avg_reg),
                                                           PITCH_LIMIT));
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign sample.ready          = (state_reg == ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.roll_instant   = out_roll_i_reg;
    assign result.pitch_instant  = out_pitch_i_reg;
    assign result.roll_smoothed  = out_roll_s_reg;
    assign result.pitch_smoothed = out_pitch_s_reg;

endmodule

>>> hdl/ats_checker.sv
// Port-level checks for the tilt angle smoother, bound to the top level.
module ats_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               s_valid,
    input logic               s_ready,
    input logic               r_valid,
    input logic               r_ready,
    input logic signed [16:0] r_roll,
    input logic signed [15:0] r_pitch
);

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted while a sample is in work");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_roll) && $stable(r_pitch))
        else $error("stalled result changed");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (r_roll <= 17'sd46080) && (r_roll >= -17'sd46080))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (r_pitch <= 16'sd23040) && (r_pitch >= -16'sd23040))
        else $error("pitch out of range");

endmodule

bind accel_tilt_angle_smoother ats_checker u_ats_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_roll  (result.roll_instant),
    .r_pitch (result.pitch_instant)
);
